// File: design/dtc_pkg.sv
package dtc_pkg;

   localparam int MAX_BITS_DEF  = 8;
   localparam int COST_BITS_DEF = 16;

   // configuration register indexes
   localparam logic [1:0] CSR_BIT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_COST_KIND  = 2'd1;
   localparam logic [1:0] CSR_SOLVE_MODE = 2'd2;

   // solve modes
   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_SUBSET = 2'd1;
   localparam logic [1:0] MODE_HELPER = 2'd2;

   // reset values
   localparam logic [3:0] BIT_COUNT_RST = 4'd4;

   typedef struct packed {
      logic truth_bit;
      logic companion_bit;
      logic last_entry;
   } req_type;

   typedef struct packed {
      logic [15:0] tree_cost;
      logic        length_error;
   } rsp_type;

   // 3 to the power k, elaboration only
   function automatic int pow3(input int k);
      int r;
      r = 1;
      for (int i = 0; i < k; i++) begin
         r = r * 3;
      end
      return r;
   endfunction

endpackage

// File: design/dtc_cost_unit.sv
// Combines the costs of two branches: 1+max for depth, 1+sum for node count,
// saturated at the all-ones cost.
module dtc_cost_unit #(
   parameter int COST_BITS = dtc_pkg::COST_BITS_DEF
) (
   input  logic                 kind,
   input  logic [COST_BITS-1:0] cost_a,
   input  logic [COST_BITS-1:0] cost_b,
   output logic [COST_BITS-1:0] cost_y
);

   logic [COST_BITS+1:0] raw;

   always_comb begin
      if (kind) begin
         raw = {2'b00, cost_a} + {2'b00, cost_b} + (COST_BITS+2)'(1);
      end else begin
         raw = {2'b00, ((cost_a > cost_b) ? cost_a : cost_b)} + (COST_BITS+2)'(1);
      end
      // saturate
      if (raw[COST_BITS+1:COST_BITS] != 2'b00) begin
         cost_y = '1;
      end else begin
         cost_y = raw[COST_BITS-1:0];
      end
   end

endmodule

// File: design/decision_tree_cost_dp.sv
// Optimal decision-tree cost of a Boolean function. Truth-table entries
// (function bit plus companion bit) are taken one per cycle in ascending index
// order while idle with no result stalled. The entry marked last checks the count
// against 2^bit_count; a wrong count answers at once with length_error set and
// cost 0. Otherwise the block drops ready and sweeps every subcube in ascending
// ternary address (digit 2 = free variable), so children are always solved
// before their parent. A leaf passes CELL and LEAF; an inner subcube passes CELL,
// HLP in helper mode's main pass, RD0, RD1 and CMB per free variable, then WR, as
// one cell memory read port feeds one shared cost unit. The sweep runs once over
// 3^bit_count cells, or three times in helper mode (helper zero, helper one, main).
module decision_tree_cost_dp #(
   parameter int MAX_BITS  = dtc_pkg::MAX_BITS_DEF,
   parameter int COST_BITS = dtc_pkg::COST_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtc_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dtc_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [3:0]       csr_wdata
);

   localparam int CELLS = dtc_pkg::pow3(MAX_BITS);
   localparam int AW    = $clog2(CELLS);
   localparam int DW    = COST_BITS + 2;
   localparam int ED    = 1 << MAX_BITS;
   localparam int CW    = MAX_BITS + 1;
   localparam int BW    = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CELL = 4'd1;
   localparam logic [3:0] ST_LEAF = 4'd2;
   localparam logic [3:0] ST_HLP  = 4'd3;
   localparam logic [3:0] ST_RD0  = 4'd4;
   localparam logic [3:0] ST_RD1  = 4'd5;
   localparam logic [3:0] ST_CMB  = 4'd6;
   localparam logic [3:0] ST_WR   = 4'd7;

   localparam logic [1:0] LAY_HZ   = 2'd0;
   localparam logic [1:0] LAY_HO   = 2'd1;
   localparam logic [1:0] LAY_MAIN = 2'd2;

   // configuration
   logic [3:0] bit_count_ff;
   logic       cost_kind_ff;
   logic [1:0] solve_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= dtc_pkg::BIT_COUNT_RST;
         cost_kind_ff  <= 1'b0;
         solve_mode_ff <= dtc_pkg::MODE_PLAIN;
      end else if (csr_we) begin
         unique case (csr_index)
            dtc_pkg::CSR_BIT_COUNT:  bit_count_ff  <= csr_wdata;
            dtc_pkg::CSR_COST_KIND:  cost_kind_ff  <= csr_wdata[0];
            dtc_pkg::CSR_SOLVE_MODE: solve_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // constant tables: 3^b and last address 3^k - 1
   logic [AW-1:0] p3_tab   [MAX_BITS];
   logic [AW-1:0] last_tab [MAX_BITS+1];

   for (genvar g = 0; g <= MAX_BITS; g++) begin : g_tab
      if (g < MAX_BITS) begin : g_p3
         assign p3_tab[g] = AW'(dtc_pkg::pow3(g));
      end
      assign last_tab[g] = AW'(dtc_pkg::pow3(g) - 1);
   end

   // sequencer state
   logic [3:0]                 state_ff, state_in;
   logic [1:0]                 layer_ff, layer_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic [MAX_BITS-1:0][1:0]   dig_ff, dig_in;
   logic [BW-1:0]              b_ff, b_in;
   logic                       first_ff, first_in;
   logic [1:0]                 seen_ff, seen_in;
   logic [COST_BITS-1:0]       best_ff, best_in;
   logic [DW-1:0]              d0_ff, d0_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   dtc_pkg::rsp_type           rsp_ff, rsp_in;

   logic req_xfer;
   assign req_ready = (state_ff == ST_IDLE) && !(rsp_valid_ff && !rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // entry buffer
   logic [1:0]          ebuf [ED];
   logic [1:0]          ebuf_rd;
   logic [MAX_BITS-1:0] leaf_idx;

   always_comb begin
      for (int i = 0; i < MAX_BITS; i++) begin
         leaf_idx[i] = dig_ff[i][0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !cnt_ff[MAX_BITS]) begin
         ebuf[cnt_ff[MAX_BITS-1:0]] <= {req.companion_bit, req.truth_bit};
      end
      ebuf_rd <= ebuf[leaf_idx];
   end

   // digit decode: leaf test, first free digit, next free digit after b
   logic          is_leaf;
   logic [BW-1:0] first_free, next_free;
   logic          has_next;

   always_comb begin
      is_leaf    = 1'b1;
      first_free = '0;
      next_free  = '0;
      has_next   = 1'b0;
      for (int i = MAX_BITS - 1; i >= 0; i--) begin
         if (dig_ff[i] == 2'd2) begin
            is_leaf    = 1'b0;
            first_free = BW'(i);
            if (i > int'(b_ff)) begin
               has_next  = 1'b1;
               next_free = BW'(i);
            end
         end
      end
   end

   // cell memories
   logic [AW-1:0] child_addr, hz_addr, ho_addr;
   logic [DW-1:0] main_rd, hz_rd, ho_rd, act_rd, wr_data;
   logic          wr_en;
   logic [DW-1:0] main_cells        [CELLS];
   logic [DW-1:0] helper_zero_cells [CELLS];
   logic [DW-1:0] helper_one_cells  [CELLS];

   assign child_addr = (state_ff == ST_RD0) ?
                       (addr_ff - {p3_tab[b_ff][AW-2:0], 1'b0}) :
                       (addr_ff - p3_tab[b_ff]);
   assign hz_addr = (layer_ff == LAY_HZ) ? child_addr : addr_ff;
   assign ho_addr = (layer_ff == LAY_HO) ? child_addr : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en && layer_ff == LAY_MAIN) begin
         main_cells[addr_ff] <= wr_data;
      end
      main_rd <= main_cells[child_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && layer_ff == LAY_HZ) begin
         helper_zero_cells[addr_ff] <= wr_data;
      end
      hz_rd <= helper_zero_cells[hz_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && layer_ff == LAY_HO) begin
         helper_one_cells[addr_ff] <= wr_data;
      end
      ho_rd <= helper_one_cells[ho_addr];
   end

   always_comb begin
      unique case (layer_ff)
         LAY_HZ:  act_rd = hz_rd;
         LAY_HO:  act_rd = ho_rd;
         default: act_rd = main_rd;
      endcase
   end

   // shared cost unit
   logic [COST_BITS-1:0] cu_a, cu_b, cu_y;

   assign cu_a = (state_ff == ST_HLP) ? hz_rd[DW-1:2] : d0_ff[DW-1:2];
   assign cu_b = (state_ff == ST_HLP) ? ho_rd[DW-1:2] : act_rd[DW-1:2];

   dtc_cost_unit #(.COST_BITS(COST_BITS)) u_cost (
      .kind   (cost_kind_ff),
      .cost_a (cu_a),
      .cost_b (cu_b),
      .cost_y (cu_y)
   );

   // leaf reachability
   logic leaf_reach;
   always_comb begin
      unique case (layer_ff)
         LAY_HZ:  leaf_reach = !ebuf_rd[1];
         LAY_HO:  leaf_reach = ebuf_rd[1];
         default: leaf_reach = (solve_mode_ff == dtc_pkg::MODE_SUBSET) ? ebuf_rd[1] : 1'b1;
      endcase
   end

   // length check on the last entry
   logic [CW:0] count_p1;
   logic        len_bad;
   assign count_p1 = {1'b0, cnt_ff} + (CW+1)'(1);
   assign len_bad  = (bit_count_ff > 4'(MAX_BITS)) ||
                     (count_p1 != ((CW+1)'(1) << bit_count_ff));

   logic [AW-1:0]        root_addr;
   logic [COST_BITS-1:0] cell_cost;
   logic [31:0]          cost_ext;
   assign root_addr = last_tab[bit_count_ff[$clog2(MAX_BITS+1)-1:0]];
   assign cell_cost = (seen_ff == 2'b11) ? best_ff : '0;

   // digit increment
   logic [MAX_BITS-1:0][1:0] dig_inc;
   always_comb begin
      logic carry;
      carry = 1'b1;
      for (int i = 0; i < MAX_BITS; i++) begin
         dig_inc[i] = dig_ff[i];
         if (carry) begin
            if (dig_ff[i] == 2'd2) begin
               dig_inc[i] = 2'd0;
            end else begin
               dig_inc[i] = dig_ff[i] + 2'd1;
               carry      = 1'b0;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      logic done;
      logic [COST_BITS-1:0] fin_cost;
      state_in     = state_ff;
      layer_in     = layer_ff;
      addr_in      = addr_ff;
      dig_in       = dig_ff;
      b_in         = b_ff;
      first_in     = first_ff;
      seen_in      = seen_ff;
      best_in      = best_ff;
      d0_in        = d0_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = {cell_cost, seen_ff};
      done         = 1'b0;
      fin_cost     = cell_cost;
      cost_ext     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!req.last_entry) begin
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end else begin
                  cnt_in = '0;
                  if (len_bad) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.tree_cost    = '0;
                     rsp_in.length_error = 1'b1;
                  end else begin
                     state_in = ST_CELL;
                     layer_in = (solve_mode_ff == dtc_pkg::MODE_HELPER) ? LAY_HZ : LAY_MAIN;
                     addr_in  = '0;
                     dig_in   = '0;
                  end
               end
            end
         end
         ST_CELL: begin
            if (is_leaf) begin
               state_in = ST_LEAF;
            end else begin
               b_in     = first_free;
               first_in = 1'b1;
               best_in  = cost_kind_ff ? '1 : COST_BITS'(bit_count_ff);
               state_in = (layer_ff == LAY_MAIN && solve_mode_ff == dtc_pkg::MODE_HELPER) ?
                          ST_HLP : ST_RD0;
            end
         end
         ST_LEAF: begin
            wr_en    = 1'b1;
            wr_data  = {{COST_BITS{1'b0}}, (leaf_reach ? (2'b01 << ebuf_rd[0]) : 2'b00)};
            fin_cost = '0;
            done     = 1'b1;
         end
         ST_HLP: begin
            best_in  = cu_y;
            state_in = ST_RD0;
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            d0_in    = act_rd;
            state_in = ST_CMB;
         end
         ST_CMB: begin
            if (first_ff) begin
               seen_in = d0_ff[1:0] | act_rd[1:0];
            end
            first_in = 1'b0;
            if (cu_y < best_ff) begin
               best_in = cu_y;
            end
            if (has_next) begin
               b_in     = next_free;
               state_in = ST_RD0;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            wr_en = 1'b1;
            done  = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase

      // advance to the next cell, layer or finish
      if (done) begin
         if (addr_ff == root_addr) begin
            if (layer_ff == LAY_MAIN) begin
               cost_ext            = 32'(fin_cost);
               rsp_valid_in        = 1'b1;
               rsp_in.tree_cost    = cost_ext[15:0];
               rsp_in.length_error = 1'b0;
               state_in            = ST_IDLE;
            end else begin
               layer_in = layer_ff + 2'd1;
               addr_in  = '0;
               dig_in   = '0;
               state_in = ST_CELL;
            end
         end else begin
            addr_in  = addr_ff + AW'(1);
            dig_in   = dig_inc;
            state_in = ST_CELL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff <= layer_in;
      addr_ff  <= addr_in;
      dig_ff   <= dig_in;
      b_ff     <= b_in;
      first_ff <= first_in;
      seen_ff  <= seen_in;
      best_ff  <= best_in;
      d0_ff    <= d0_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: design/dtc_checker.sv
module dtc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input dtc_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dtc_pkg::rsp_type rsp
);

   // a waiting result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result dropped or changed while stalled");

   // no input is taken while a result is stalled
   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // a length error always reports zero cost
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.length_error |-> rsp.tree_cost == 16'd0)
      else $error("length error with nonzero cost");

   // a transfer that is not the last entry never causes a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req.last_entry && !rsp_valid |=> !rsp_valid)
      else $error("result without last entry");

endmodule

bind decision_tree_cost_dp dtc_checker u_dtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

// File: test/decision_tree_cost_dp_test.sv
module decision_tree_cost_dp_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOP_BITS   = dtc_pkg::MAX_BITS_DEF;
   localparam int CELL_COUNT = 6561;
   localparam int ENTRY_CAP  = 1 << TOP_BITS;
   localparam int COUNT_TOP  = (1 << (TOP_BITS + 1)) - 1;
   localparam int COST_TOP   = (1 << dtc_pkg::COST_BITS_DEF) - 1;
   localparam int HZ_LAYER   = 0;
   localparam int HO_LAYER   = 1;
   localparam int MAIN_LAYER = 2;
   // leaf reachability selection
   localparam int REACH_ALL  = 0;
   localparam int REACH_ONE  = 1;
   localparam int REACH_ZERO = 2;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dtc_pkg::req_type req;
   logic             rsp_valid;
   logic             rsp_ready;
   dtc_pkg::rsp_type rsp;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [3:0] csr_wdata;

   decision_tree_cost_dp dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req(req),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block state
   logic [3:0] var_count;
   logic       node_cost;
   logic [1:0] mode_sel;
   int         entries_seen;
   logic [1:0] entry_store [ENTRY_CAP];
   int         row_base [ENTRY_CAP];
   int         cells [3][CELL_COUNT];

   dtc_pkg::rsp_type cost_queue[$];
   int         error_count;
   int         entries_sent;
   bit         calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic int join_cost(input int a, input int b);
      int r;
      if (node_cost) r = 1 + a + b;
      else r = 1 + ((a > b) ? a : b);
      return (r > COST_TOP) ? COST_TOP : r;
   endfunction

   // insert value v at position pos of the free-variable values
   function automatic int widen(input int vals, input int pos, input int v);
      int low;
      int high;
      low  = vals & ((1 << pos) - 1);
      high = vals & ~((1 << pos) - 1);
      return low | (v << pos) | (high << 1);
   endfunction

   function automatic void seed_leaves(input int lay, input int n, input int sel);
      int  full;
      bit  reach;
      full = (1 << n) - 1;
      for (int v = 0; v <= full; v++) begin
         reach = (sel == REACH_ALL) ||
                 ((sel == REACH_ONE) ? entry_store[v][1] : !entry_store[v][1]);
         cells[lay][row_base[full] + v] = reach ? (1 << entry_store[v][0]) : 0;
      end
   endfunction

   // children (one more fixed variable) are always done before the parent
   function automatic void sweep_layer(input int lay, input int n, input bit helped);
      int full, states, first, fpos, cbase, seen, best, pos, idx, c, lo, hi;
      full = (1 << n) - 1;
      for (int m = full - 1; m >= 0; m--) begin
         states = 1 << $countones(m);
         first = 0;
         while ((m >> first) & 1) first++;
         fpos  = $countones(m & ((1 << first) - 1));
         cbase = row_base[m | (1 << first)];
         for (int v = 0; v < states; v++) begin
            idx  = row_base[m] + v;
            seen = (cells[lay][cbase + widen(v, fpos, 0)] |
                    cells[lay][cbase + widen(v, fpos, 1)]) & 3;
            if (seen != 3) begin
               cells[lay][idx] = seen;
            end else begin
               best = node_cost ? COST_TOP : n;
               if (helped)
                  best = join_cost(cells[HZ_LAYER][idx] >> 2, cells[HO_LAYER][idx] >> 2);
               for (int b = 0; b < n; b++) begin
                  if (!((m >> b) & 1)) begin
                     pos = $countones(m & ((1 << b) - 1));
                     lo  = cells[lay][row_base[m | (1 << b)] + widen(v, pos, 0)] >> 2;
                     hi  = cells[lay][row_base[m | (1 << b)] + widen(v, pos, 1)] >> 2;
                     c   = join_cost(lo, hi);
                     if (c < best) best = c;
                  end
               end
               cells[lay][idx] = 3 | (best << 2);
            end
         end
      end
   endfunction

   function automatic int root_cost(input int n);
      int acc;
      acc = 0;
      for (int m = 0; m < (1 << n); m++) begin
         row_base[m] = acc;
         acc += 1 << $countones(m);
      end
      if (mode_sel == dtc_pkg::MODE_HELPER) begin
         seed_leaves(HZ_LAYER, n, REACH_ZERO);
         seed_leaves(HO_LAYER, n, REACH_ONE);
         seed_leaves(MAIN_LAYER, n, REACH_ALL);
         sweep_layer(HZ_LAYER, n, 1'b0);
         sweep_layer(HO_LAYER, n, 1'b0);
         sweep_layer(MAIN_LAYER, n, 1'b1);
      end else begin
         seed_leaves(MAIN_LAYER, n,
                     (mode_sel == dtc_pkg::MODE_SUBSET) ? REACH_ONE : REACH_ALL);
         sweep_layer(MAIN_LAYER, n, 1'b0);
      end
      return cells[MAIN_LAYER][row_base[0]] >> 2;
   endfunction

   // update the shadow state for one accepted entry
   task automatic take_entry(input dtc_pkg::req_type r);
      dtc_pkg::rsp_type res;
      int      count;
      if (entries_seen < ENTRY_CAP) entry_store[entries_seen] = {r.companion_bit, r.truth_bit};
      if (!r.last_entry) begin
         if (entries_seen < COUNT_TOP) entries_seen++;
      end else begin
         count = entries_seen + 1;
         entries_seen = 0;
         if (var_count > TOP_BITS || count != (1 << var_count)) begin
            res.tree_cost    = '0;
            res.length_error = 1'b1;
         end else begin
            res.tree_cost    = 16'(root_cost(int'(var_count)));
            res.length_error = 1'b0;
         end
         cost_queue = {cost_queue, res};
      end
   endtask

   // result side: random stalls, compare each transfer
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = calm || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      dtc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cost_queue.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            want = cost_queue.pop_front();
            if (rsp.tree_cost !== want.tree_cost)
               report_mismatch($sformatf("tree_cost %0d, expected %0d",
                                         rsp.tree_cost, want.tree_cost));
            if (rsp.length_error !== want.length_error)
               report_mismatch($sformatf("length_error %0b, expected %0b",
                                         rsp.length_error, want.length_error));
         end
      end
   end

   // one entry transfer; returns right after the accepting edge
   task automatic send_entry(input logic t, input logic c, input logic l);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_valid = 1'b1;
      req = '{truth_bit: t, companion_bit: c, last_entry: l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_entry(req);
      entries_sent++;
   endtask

   // count entries; fixed 16-bit patterns or random bits at chosen densities
   task automatic send_table(input int count, input logic [15:0] truth_pat,
                             input logic [15:0] comp_pat, input bit scramble);
      int  t_odds;
      int  c_odds;
      logic t;
      logic c;
      t_odds = $urandom_range(0, 100);
      c_odds = $urandom_range(0, 100);
      for (int i = 0; i < count; i++) begin
         if (scramble) begin
            t = $urandom_range(99) < t_odds;
            c = $urandom_range(99) < c_odds;
         end else begin
            t = truth_pat[i % 16];
            c = comp_pat[i % 16];
         end
         send_entry(t, c, i == count - 1);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (cost_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         dtc_pkg::CSR_BIT_COUNT:  var_count = val;
         dtc_pkg::CSR_COST_KIND:  node_cost = val[0];
         dtc_pkg::CSR_SOLVE_MODE: mode_sel = val[1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int n, input bit kind, input logic [1:0] mode);
      write_reg(dtc_pkg::CSR_BIT_COUNT, 4'(n));
      write_reg(dtc_pkg::CSR_COST_KIND, {3'b0, kind});
      write_reg(dtc_pkg::CSR_SOLVE_MODE, {2'b0, mode});
   endtask

   // edge cases at tiny sizes
   task automatic test_directed();
      calm = 1'b1;
      send_table(3, 16'h0007, 16'h0000, 1'b0);      // reset config, short count
      set_config(0, 1'b0, dtc_pkg::MODE_PLAIN);
      send_table(1, 16'h0001, 16'h0001, 1'b0);      // no variables
      send_table(2, 16'h0000, 16'h0000, 1'b0);      // too many for zero variables
      set_config(1, 1'b0, dtc_pkg::MODE_PLAIN);
      send_table(2, 16'h0002, 16'h0000, 1'b0);
      set_config(2, 1'b1, dtc_pkg::MODE_PLAIN);
      send_table(4, 16'h0006, 16'hFFFF, 1'b0);      // parity, node count
      set_config(2, 1'b1, dtc_pkg::MODE_SUBSET);
      send_table(4, 16'h0006, 16'h0000, 1'b0);      // nothing reachable
      send_table(4, 16'h0006, 16'h0009, 1'b0);
      set_config(2, 1'b0, dtc_pkg::MODE_HELPER);
      send_table(4, 16'h0006, 16'h0006, 1'b0);      // helper equals function
      set_config(9, 1'b0, 2'd3);
      send_table(1, 16'h0000, 16'h0000, 1'b0);      // beyond the largest size
      calm = 1'b0;
   endtask

   // counter saturates; a wrapping count would match the single entry expected
   task automatic test_overflow();
      set_config(0, 1'b1, dtc_pkg::MODE_PLAIN);
      send_table(COUNT_TOP + 2, 16'h0000, 16'h0000, 1'b1);
   endtask

   task automatic test_largest();
      set_config(TOP_BITS, 1'b1, dtc_pkg::MODE_HELPER);
      send_table(ENTRY_CAP, 16'h0000, 16'h0000, 1'b1);
   endtask

   task automatic test_random();
      int pick;
      int n;
      int goal;
      int len;
      goal = entries_sent + 150;
      calm = 1'b1;
      while (entries_sent < goal) begin
         if (entries_sent > goal - 90) calm = 1'b0;
         pick = $urandom_range(99);
         if (pick < 40) n = $urandom_range(1, 3);
         else if (pick < 80) n = 4;
         else if (pick < 90) n = 5;
         else if (pick < 94) n = 6;
         else if (pick < 97) n = 0;
         else n = $urandom_range(TOP_BITS + 1, 15);
         set_config(n, 1'($urandom_range(1)), 2'($urandom_range(3)));
         repeat ($urandom_range(1, 3)) begin
            len = (n > TOP_BITS) ? $urandom_range(1, 8) : (1 << n);
            if ($urandom_range(99) < 10) len = $urandom_range(1, (1 << (n % 9)) + 2);
            send_table(len, 16'h0000, 16'h0000, 1'b1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req = '0;
      csr_we = 1'b0;
      csr_index = dtc_pkg::CSR_BIT_COUNT;
      csr_wdata = '0;
      var_count = dtc_pkg::BIT_COUNT_RST;
      node_cost = 1'b0;
      mode_sel = dtc_pkg::MODE_PLAIN;
      entries_seen = 0;
      error_count = 0;
      entries_sent = 0;
      calm = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random();
      test_overflow();
      test_largest();

      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0 && cost_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/dtc_pkg.sv
design/dtc_cost_unit.sv
design/decision_tree_cost_dp.sv
design/dtc_checker.sv
test/decision_tree_cost_dp_test.sv
